// ----- rtl/ctc_pkg.sv -----
package ctc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 10;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CfgDebounceTicks = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgBeepLength    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSecondLength  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgNoteLength    = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgMaxSeconds    = 3'd4;

  // Number of notes in the end-of-countdown jingle (1 to 3)
  localparam logic [1:0] JingleNotes = 2'd3;

  localparam logic [3:0] SecondsCeiling = 4'd9;
  localparam logic [3:0] SecondsReset   = 4'd5;

  localparam logic [7:0] ToneReset = 8'd255;
  localparam logic [7:0] ToneStart = 8'd255;
  localparam logic [7:0] TonePause = 8'd155;
  localparam logic [7:0] TonePower = 8'd195;

  localparam logic [2:0] PowerBarLow  = 3'b100;
  localparam logic [2:0] PowerBarMid  = 3'b110;
  localparam logic [2:0] PowerBarHigh = 3'b111;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [9:0] beep_length_ms;
    logic [9:0] second_length_ms;
    logic [9:0] note_length_ms;
    logic [3:0] max_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0] run_mode;
    logic [3:0] seconds_shown;
    logic       digit_select;
    logic [6:0] segments;
    logic [3:0] mode_leds;
    logic [2:0] power_leds;
    logic       buzzer_on;
    logic [7:0] tone_top;
  } result_t;

  function automatic logic [7:0] note_tone(input logic [1:0] note);
    case (note)
      2'd0:    note_tone = 8'd220;
      2'd1:    note_tone = 8'd180;
      2'd2:    note_tone = 8'd150;
      default: note_tone = 8'd220;
    endcase
  endfunction

  function automatic logic [3:0] preset_seconds(input logic [1:0] mode);
    case (mode)
      2'd0:    preset_seconds = 4'd5;
      2'd1:    preset_seconds = 4'd7;
      2'd2:    preset_seconds = 4'd3;
      default: preset_seconds = 4'd9;
    endcase
  endfunction

  function automatic logic [6:0] digit_segments(input logic [3:0] digit);
    case (digit)
      4'd0:    digit_segments = 7'd63;
      4'd1:    digit_segments = 7'd6;
      4'd2:    digit_segments = 7'd91;
      4'd3:    digit_segments = 7'd79;
      4'd4:    digit_segments = 7'd102;
      4'd5:    digit_segments = 7'd109;
      4'd6:    digit_segments = 7'd125;
      4'd7:    digit_segments = 7'd7;
      4'd8:    digit_segments = 7'd127;
      4'd9:    digit_segments = 7'd111;
      default: digit_segments = 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] mode_segments(input logic [1:0] mode);
    case (mode)
      2'd0:    mode_segments = 7'd103;
      2'd1:    mode_segments = 7'd115;
      2'd2:    mode_segments = 7'd124;
      default: mode_segments = 7'd94;
    endcase
  endfunction

endpackage

// ----- rtl/cook_timer_controller.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------
// cfg      cfg_write            cfg_index, cfg_data (register written at once)
// in       in_valid / in_stall  raw_start_button, raw_pause_button,
//                               power_press, mode_switch (one 1 ms tick)
// out      out_valid / out_stall run_mode, seconds_shown, digit_select,
//                               segments, mode_leds, power_leds, buzzer_on,
//                               tone_top
//
// Each tick passes two register stages: it is accepted into the input register,
// and the controller logic loads its result into the result register when not stalled.
// A new tick is taken every unstalled cycle; the single state update per tick sets it.
// in_stall rises only while the input register is full and the result
// register holds a transaction that the receiver stalls.
// Reset (rst, synchronous) clears all controller state and loads the
// configuration defaults; write configuration only while no tick is in flight.
module cook_timer_controller
  import ctc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     raw_start_button,
  input  logic                     raw_pause_button,
  input  logic                     power_press,
  input  logic [1:0]               mode_switch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               run_mode,
  output logic [3:0]               seconds_shown,
  output logic                     digit_select,
  output logic [6:0]               segments,
  output logic [3:0]               mode_leds,
  output logic [2:0]               power_leds,
  output logic                     buzzer_on,
  output logic [7:0]               tone_top
);

  cfg_t       cfg;
  logic       in_full;
  logic       advance;
  logic       in_accept;
  logic       step;
  logic       start_q, pause_q, power_q;
  logic [1:0] mode_q;
  result_t    result;

  // Advance the result stage whenever it is empty or being drained.
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step      = in_full && advance;

  // Configuration registers: write straight through, unknown indexes dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= 8'd25;
      cfg.beep_length_ms   <= 10'd250;
      cfg.second_length_ms <= 10'd1000;
      cfg.note_length_ms   <= 10'd250;
      cfg.max_seconds      <= 4'd9;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgDebounceTicks: cfg.debounce_ticks   <= cfg_data[7:0];
        CfgBeepLength:    cfg.beep_length_ms   <= cfg_data;
        CfgSecondLength:  cfg.second_length_ms <= cfg_data;
        CfgNoteLength:    cfg.note_length_ms   <= cfg_data;
        CfgMaxSeconds:    cfg.max_seconds      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the tick until the controller consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      start_q <= raw_start_button;
      pause_q <= raw_pause_button;
      power_q <= power_press;
      mode_q  <= mode_switch;
    end
  end

  ctc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cfg         (cfg),
    .start_level (start_q),
    .pause_level (pause_q),
    .power_press (power_q),
    .mode_switch (mode_q),
    .result      (result)
  );

  // Result register: load on each consumed tick, hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      run_mode      <= result.run_mode;
      seconds_shown <= result.seconds_shown;
      digit_select  <= result.digit_select;
      segments      <= result.segments;
      mode_leds     <= result.mode_leds;
      power_leds    <= result.power_leds;
      buzzer_on     <= result.buzzer_on;
      tone_top      <= result.tone_top;
    end
  end

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid)
    else $error("input stalled without a waiting transaction");

  a_step_delivers: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("consumed tick produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(run_mode) && $stable(tone_top))
    else $error("stalled result changed");

endmodule

// ----- rtl/ctc_debounce.sv -----
module ctc_debounce
  import ctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       level,
  input  logic [7:0] debounce_ticks,
  output logic       release_seen
);

  logic       candidate, candidate_next;
  logic       reported, reported_next;
  logic [7:0] stable_count, stable_count_next;

  always_comb begin
    candidate_next    = candidate;
    reported_next     = reported;
    stable_count_next = stable_count;
    release_seen      = 1'b0;
    if (level == candidate) begin
      if (stable_count != 8'd255) stable_count_next = stable_count + 8'd1;
    end else begin
      stable_count_next = 8'd0;
      candidate_next    = level;
    end
    // accept the level once it has held long enough; report falling levels
    if (stable_count_next >= debounce_ticks) begin
      release_seen  = reported && !candidate_next;
      reported_next = candidate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate    <= 1'b0;
      reported     <= 1'b0;
      stable_count <= 8'd0;
    end else if (step) begin
      candidate    <= candidate_next;
      reported     <= reported_next;
      stable_count <= stable_count_next;
    end
  end

endmodule

// ----- rtl/ctc_core.sv -----
module ctc_core
  import ctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  cfg_t       cfg,
  input  logic       start_level,
  input  logic       pause_level,
  input  logic       power_press,
  input  logic [1:0] mode_switch,
  output result_t    result
);

  typedef enum logic [1:0] {
    IDLE    = 2'd0,
    RUNNING = 2'd1,
    PAUSED  = 2'd2
  } run_state_t;

  run_state_t run_state, run_state_next;
  logic [3:0] seconds_left, seconds_left_next;
  logic [1:0] mode_index, mode_index_next;
  logic [1:0] last_mode, last_mode_next;
  logic [1:0] heat_level, heat_level_next;
  logic [9:0] second_counter, second_counter_next;
  logic [9:0] beep_counter, beep_counter_next;
  logic       second_pending, second_pending_next;
  logic       beep_pending, beep_pending_next;
  logic       buzzer_enable, buzzer_enable_next;
  logic [7:0] tone_value, tone_value_next;
  logic       jingle_active, jingle_active_next;
  logic [1:0] jingle_note, jingle_note_next;
  logic [9:0] note_timer, note_timer_next;
  logic       jingle_done, jingle_done_next;
  logic       display_phase, display_phase_next;
  logic       start_release, start_release_next;
  logic       pause_release, pause_release_next;

  logic       start_seen, pause_seen;
  logic [3:0] ceiling;

  ctc_debounce u_start_db (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .level          (start_level),
    .debounce_ticks (cfg.debounce_ticks),
    .release_seen   (start_seen)
  );

  ctc_debounce u_pause_db (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .level          (pause_level),
    .debounce_ticks (cfg.debounce_ticks),
    .release_seen   (pause_seen)
  );

  assign ceiling = (cfg.max_seconds > SecondsCeiling) ? SecondsCeiling : cfg.max_seconds;

  always_comb begin
    run_state_next      = run_state;
    seconds_left_next   = seconds_left;
    mode_index_next     = mode_index;
    last_mode_next      = last_mode;
    heat_level_next     = heat_level;
    second_counter_next = second_counter;
    beep_counter_next   = beep_counter;
    second_pending_next = second_pending;
    beep_pending_next   = beep_pending;
    buzzer_enable_next  = buzzer_enable;
    tone_value_next     = tone_value;
    jingle_active_next  = jingle_active;
    jingle_note_next    = jingle_note;
    note_timer_next     = note_timer;
    jingle_done_next    = jingle_done;
    display_phase_next  = ~display_phase;
    start_release_next  = start_release | start_seen;
    pause_release_next  = pause_release | pause_seen;

    // power press: cycle the level, cut the jingle, start a beep
    if (power_press) begin
      heat_level_next    = (heat_level >= 2'd2) ? 2'd0 : heat_level + 2'd1;
      jingle_active_next = 1'b0;
      jingle_note_next   = 2'd0;
      note_timer_next    = 10'd0;
      buzzer_enable_next = 1'b1;
      tone_value_next    = TonePower;
      beep_pending_next  = 1'b0;
      beep_counter_next  = 10'd0;
    end

    second_counter_next = second_counter_next + 10'd1;
    beep_counter_next   = beep_counter_next + 10'd1;
    if (jingle_active_next) begin
      note_timer_next = note_timer_next + 10'd1;
      if (note_timer_next >= cfg.note_length_ms) begin
        jingle_note_next = jingle_note_next + 2'd1;
        note_timer_next  = 10'd0;
        if (jingle_note_next >= JingleNotes) begin
          jingle_active_next = 1'b0;
          jingle_note_next   = 2'd0;
          buzzer_enable_next = 1'b0;
        end else begin
          tone_value_next = note_tone(jingle_note_next);
        end
      end
    end
    if (second_counter_next >= cfg.second_length_ms) begin
      second_pending_next = 1'b1;
      second_counter_next = 10'd0;
    end
    if (beep_counter_next >= cfg.beep_length_ms) begin
      beep_pending_next = 1'b1;
      beep_counter_next = 10'd0;
    end

    // end a key beep once its period has elapsed, unless the jingle owns the buzzer
    if (beep_pending_next && !jingle_active_next) begin
      beep_pending_next  = 1'b0;
      beep_counter_next  = 10'd0;
      buzzer_enable_next = 1'b0;
    end

    unique case (run_state)
      IDLE: begin
        mode_index_next   = mode_switch;
        seconds_left_next = preset_seconds(mode_switch);
        last_mode_next    = mode_switch;
        jingle_done_next  = 1'b0;
        if (start_release_next) begin
          start_release_next  = 1'b0;
          jingle_active_next  = 1'b0;
          jingle_note_next    = 2'd0;
          note_timer_next     = 10'd0;
          buzzer_enable_next  = 1'b1;
          tone_value_next     = ToneStart;
          beep_counter_next   = 10'd0;
          beep_pending_next   = 1'b0;
          second_counter_next = 10'd0;
          second_pending_next = 1'b0;
          run_state_next      = RUNNING;
        end
      end
      RUNNING: begin
        if (second_pending_next) begin
          second_pending_next = 1'b0;
          if (seconds_left_next != 4'd0) begin
            seconds_left_next = seconds_left_next - 4'd1;
          end else begin
            // countdown at zero: play the jingle once per run
            if (!jingle_done_next && !jingle_active_next) begin
              beep_pending_next  = 1'b0;
              beep_counter_next  = 10'd0;
              jingle_active_next = 1'b1;
              jingle_note_next   = 2'd0;
              note_timer_next    = 10'd0;
              buzzer_enable_next = 1'b1;
              tone_value_next    = note_tone(2'd0);
              jingle_done_next   = 1'b1;
            end
            if (mode_switch != last_mode_next) begin
              last_mode_next = mode_switch;
              run_state_next = IDLE;
              if (jingle_active_next) begin
                jingle_active_next = 1'b0;
                jingle_note_next   = 2'd0;
                note_timer_next    = 10'd0;
                buzzer_enable_next = 1'b0;
              end
            end
          end
        end
        if (start_release_next) begin
          start_release_next  = 1'b0;
          jingle_active_next  = 1'b0;
          jingle_note_next    = 2'd0;
          note_timer_next     = 10'd0;
          second_counter_next = 10'd0;
          buzzer_enable_next  = 1'b1;
          tone_value_next     = ToneStart;
          beep_counter_next   = 10'd0;
          beep_pending_next   = 1'b0;
          seconds_left_next   = (seconds_left_next < ceiling) ?
                                seconds_left_next + 4'd1 : ceiling;
        end
        if (pause_release_next) begin
          pause_release_next  = 1'b0;
          jingle_active_next  = 1'b0;
          jingle_note_next    = 2'd0;
          note_timer_next     = 10'd0;
          second_counter_next = 10'd0;
          buzzer_enable_next  = 1'b1;
          tone_value_next     = TonePause;
          beep_counter_next   = 10'd0;
          beep_pending_next   = 1'b0;
          run_state_next      = PAUSED;
        end
      end
      PAUSED: begin
        // pause first, then start: both together resume
        if (pause_release_next) begin
          pause_release_next  = 1'b0;
          jingle_active_next  = 1'b0;
          jingle_note_next    = 2'd0;
          note_timer_next     = 10'd0;
          second_counter_next = 10'd0;
          buzzer_enable_next  = 1'b1;
          tone_value_next     = TonePause;
          beep_counter_next   = 10'd0;
          beep_pending_next   = 1'b0;
          run_state_next      = IDLE;
        end
        if (start_release_next) begin
          start_release_next  = 1'b0;
          jingle_active_next  = 1'b0;
          jingle_note_next    = 2'd0;
          note_timer_next     = 10'd0;
          second_counter_next = 10'd0;
          buzzer_enable_next  = 1'b1;
          tone_value_next     = ToneStart;
          beep_counter_next   = 10'd0;
          beep_pending_next   = 1'b0;
          run_state_next      = RUNNING;
        end
      end
      default: begin
        run_state_next = IDLE;
      end
    endcase
  end

  always_comb begin
    result.run_mode      = run_state_next;
    result.seconds_shown = seconds_left_next;
    result.digit_select  = display_phase_next;
    result.segments      = display_phase_next ? mode_segments(mode_index_next) :
                           digit_segments(seconds_left_next);
    result.mode_leds     = 4'b0001 << mode_index_next;
    case (heat_level_next)
      2'd0:    result.power_leds = PowerBarLow;
      2'd1:    result.power_leds = PowerBarMid;
      default: result.power_leds = PowerBarHigh;
    endcase
    result.buzzer_on     = buzzer_enable_next;
    result.tone_top      = tone_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state      <= IDLE;
      seconds_left   <= SecondsReset;
      mode_index     <= 2'd0;
      last_mode      <= 2'd0;
      heat_level     <= 2'd0;
      second_counter <= 10'd0;
      beep_counter   <= 10'd0;
      second_pending <= 1'b0;
      beep_pending   <= 1'b0;
      buzzer_enable  <= 1'b0;
      tone_value     <= ToneReset;
      jingle_active  <= 1'b0;
      jingle_note    <= 2'd0;
      note_timer     <= 10'd0;
      jingle_done    <= 1'b0;
      display_phase  <= 1'b0;
      start_release  <= 1'b0;
      pause_release  <= 1'b0;
    end else if (step) begin
      run_state      <= run_state_next;
      seconds_left   <= seconds_left_next;
      mode_index     <= mode_index_next;
      last_mode      <= last_mode_next;
      heat_level     <= heat_level_next;
      second_counter <= second_counter_next;
      beep_counter   <= beep_counter_next;
      second_pending <= second_pending_next;
      beep_pending   <= beep_pending_next;
      buzzer_enable  <= buzzer_enable_next;
      tone_value     <= tone_value_next;
      jingle_active  <= jingle_active_next;
      jingle_note    <= jingle_note_next;
      note_timer     <= note_timer_next;
      jingle_done    <= jingle_done_next;
      display_phase  <= display_phase_next;
      start_release  <= start_release_next;
      pause_release  <= pause_release_next;
    end
  end

  a_jingle_sounds: assert property (@(posedge clk) disable iff (rst)
    jingle_active |-> buzzer_enable && jingle_done)
    else $error("jingle active without buzzer or done mark");

  a_jingle_running: assert property (@(posedge clk) disable iff (rst)
    jingle_active |-> run_state == RUNNING)
    else $error("jingle active outside running");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    seconds_left <= SecondsCeiling)
    else $error("seconds left above nine");

endmodule
